/* rtl/ctp_pkg.sv */
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and codes for the CAN transport-layer receive reassembler.
// ----------------------------------------------------------------------------
package ctp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_FC   = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Flow status codes
  localparam logic [1:0] FS_CONTINUE = 2'd0;
  localparam logic [1:0] FS_WAIT     = 2'd1;
  localparam logic [1:0] FS_ABORT    = 2'd2;

  // End record status codes
  localparam logic [1:0] ES_OK     = 2'd0;
  localparam logic [1:0] ES_NODATA = 2'd1;
  localparam logic [1:0] ES_UNSUP  = 2'd2;
  localparam logic [1:0] ES_ABORT  = 2'd3;

  // Protocol control nibbles
  localparam logic [3:0] PCI_SINGLE = 4'h0;
  localparam logic [3:0] PCI_FIRST  = 4'h1;

  // Register indexes
  localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] REG_SEP_TIME   = 2'd1;
  localparam logic [1:0] REG_MAX_WAIT   = 2'd2;

  // Register reset values
  localparam logic [7:0] BLOCK_SIZE_RST = 8'd8;
  localparam logic [7:0] SEP_TIME_RST   = 8'd10;
  localparam logic [7:0] MAX_WAIT_RST   = 8'd3;

  // Payload bytes per frame type
  localparam logic [2:0]  SF_MAX_BYTES = 3'd7;
  localparam logic [2:0]  FF_MAX_BYTES = 3'd6;
  localparam logic [2:0]  CF_MAX_BYTES = 3'd7;
  localparam logic [8:0]  POLLS_MAX    = 9'd511;

  localparam int DATA_SLOTS = 7;

  typedef struct packed {
    logic [7:0] block_size;
    logic [7:0] sep_time;
    logic [7:0] max_wait;
  } cfg_t;

  typedef struct packed {
    logic        receiving;
    logic [11:0] bytes_remaining;
    logic [11:0] declared_length;
    logic [7:0]  frames_in_block;
    logic [8:0]  empty_polls;
  } rx_state_t;

  // Everything one transaction emits: data bytes, then flow control, then end
  typedef struct packed {
    logic [DATA_SLOTS-1:0][7:0] data;
    logic [2:0]                 n_data;
    logic                       fc_en;
    logic [1:0]                 fc_status;
    logic [7:0]                 fc_block_size;
    logic [7:0]                 fc_sep_time;
    logic                       end_en;
    logic [11:0]                end_length;
    logic [1:0]                 end_status;
  } plan_t;

endpackage

/* rtl/ctp_decode.sv */
// ----------------------------------------------------------------------------
// ctp_decode
// Decodes one frame or empty poll against the receive state into the list of
// results it causes and the next receive state.
// ----------------------------------------------------------------------------
module ctp_decode
  import ctp_pkg::*;
(
  input  cfg_t           cfg,
  input  rx_state_t      st,
  input  logic           frame_present,
  input  logic [7:0][7:0] frame,
  output plan_t          plan,
  output rx_state_t      st_next
);

  logic [3:0]  pci;
  logic [3:0]  len_nib;
  logic [11:0] decl;
  logic [2:0]  sf_take;
  logic [2:0]  ff_take;
  logic [2:0]  cf_take;
  logic [11:0] rem_after;
  logic [7:0]  fib_inc;
  logic [8:0]  polls_inc;
  logic        from_byte2;

  assign pci     = frame[0][7:4];
  assign len_nib = frame[0][3:0];
  assign decl    = {len_nib, frame[1]};
  assign sf_take = (len_nib > 4'd7) ? SF_MAX_BYTES : len_nib[2:0];
  assign ff_take = (decl < 12'd6) ? decl[2:0] : FF_MAX_BYTES;
  assign cf_take = (st.bytes_remaining < 12'd7) ? st.bytes_remaining[2:0]
                                                : CF_MAX_BYTES;
  assign rem_after = st.bytes_remaining - {9'd0, cf_take};
  assign fib_inc   = st.frames_in_block + 8'd1;
  assign polls_inc = (st.empty_polls == POLLS_MAX) ? st.empty_polls
                                                   : st.empty_polls + 9'd1;
  // First frames carry data from byte 2, all others from byte 1
  assign from_byte2 = !st.receiving && (pci == PCI_FIRST);

  // Data byte window, result list and state update
  always_comb begin
    for (int i = 0; i < DATA_SLOTS; i++) begin
      if (from_byte2) begin
        plan.data[i] = (i + 2 < 8) ? frame[(i + 2) % 8] : 8'd0;
      end else begin
        plan.data[i] = frame[i + 1];
      end
    end

    plan.n_data        = 3'd0;
    plan.fc_en         = 1'b0;
    plan.fc_status     = FS_CONTINUE;
    plan.fc_block_size = 8'd0;
    plan.fc_sep_time   = 8'd0;
    plan.end_en        = 1'b0;
    plan.end_length    = 12'd0;
    plan.end_status    = ES_OK;
    st_next            = st;

    if (!st.receiving) begin
      if (!frame_present) begin
        plan.end_en     = 1'b1;
        plan.end_status = ES_NODATA;
      end else if (pci == PCI_SINGLE) begin
        plan.n_data     = sf_take;
        plan.end_en     = 1'b1;
        plan.end_length = {9'd0, sf_take};
        plan.end_status = (sf_take != 3'd0) ? ES_OK : ES_NODATA;
      end else if (pci == PCI_FIRST) begin
        plan.n_data        = ff_take;
        plan.fc_en         = 1'b1;
        plan.fc_block_size = cfg.block_size;
        plan.fc_sep_time   = cfg.sep_time;
        if (decl <= 12'd6) begin
          plan.end_en     = 1'b1;
          plan.end_length = decl;
          plan.end_status = (decl != 12'd0) ? ES_OK : ES_NODATA;
        end else begin
          st_next.receiving       = 1'b1;
          st_next.declared_length = decl;
          st_next.bytes_remaining = decl - 12'd6;
          st_next.frames_in_block = 8'd0;
          st_next.empty_polls     = 9'd0;
        end
      end else begin
        plan.end_en     = 1'b1;
        plan.end_status = ES_UNSUP;
      end
    end else if (frame_present) begin
      // Consecutive frame
      plan.n_data             = cf_take;
      st_next.empty_polls     = 9'd0;
      st_next.bytes_remaining = rem_after;
      st_next.frames_in_block = fib_inc;
      if (cfg.block_size != 8'd0 && fib_inc >= cfg.block_size) begin
        st_next.frames_in_block = 8'd0;
        plan.fc_en              = 1'b1;
        plan.fc_block_size      = cfg.block_size;
        plan.fc_sep_time        = cfg.sep_time;
      end
      if (rem_after == 12'd0) begin
        plan.end_en       = 1'b1;
        plan.end_length   = st.declared_length;
        st_next.receiving = 1'b0;
      end
    end else begin
      // Empty poll mid-message: wait, or abort past the retry limit
      plan.fc_en = 1'b1;
      if (polls_inc > {1'b0, cfg.max_wait}) begin
        plan.fc_status          = FS_ABORT;
        plan.end_en             = 1'b1;
        plan.end_length         = st.declared_length;
        plan.end_status         = ES_ABORT;
        st_next.receiving       = 1'b0;
        st_next.bytes_remaining = 12'd0;
        st_next.frames_in_block = 8'd0;
        st_next.empty_polls     = 9'd0;
      end else begin
        plan.fc_status      = FS_WAIT;
        plan.fc_sep_time    = cfg.sep_time;
        st_next.empty_polls = polls_inc;
      end
    end
  end

endmodule

/* rtl/can_tp_reassembly_receiver_unit.sv */
// ----------------------------------------------------------------------------
// can_tp_reassembly_receiver_unit
// The first result of a transaction is shown in the cycle after it is accepted.
// A transaction yielding N results (1 to 9) holds the result register until all
// are taken, one result per cycle while out_stall is low; the next one is
// accepted in the cycle the last result is taken, so back-to-back one-result
// items flow at one per cycle while out_stall is low. Synchronous reset returns
// to idle and restores the register defaults (block size 8, separation time 10, retries 3).
// ----------------------------------------------------------------------------
module can_tp_reassembly_receiver_unit
  import ctp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Frame input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        frame_present,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte1,
  input  logic [7:0]  byte2,
  input  logic [7:0]  byte3,
  input  logic [7:0]  byte4,
  input  logic [7:0]  byte5,
  input  logic [7:0]  byte6,
  input  logic [7:0]  byte7,
  // Result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [1:0]  fc_status,
  output logic [7:0]  fc_block_size,
  output logic [7:0]  fc_sep_time,
  output logic [11:0] message_length,
  output logic [1:0]  end_status,
  output logic        last,
  // Register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t            cfg;
  rx_state_t       st;
  rx_state_t       st_next;
  plan_t           plan;
  plan_t           plan_next;
  logic            busy;
  logic [3:0]      pos;
  logic [3:0]      total;
  logic            is_last;
  logic            out_take;
  logic            in_take;
  logic [7:0][7:0] frame;

  assign frame = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};

  // Handshakes
  assign cfg_ready = 1'b1;
  assign out_valid = busy;
  assign out_take  = busy && !out_stall;
  assign total     = {1'b0, plan.n_data} + {3'd0, plan.fc_en} + {3'd0, plan.end_en};
  assign is_last   = (pos + 4'd1) == total;
  assign in_stall  = busy && !(out_take && is_last);
  assign in_take   = in_valid && !in_stall;

  ctp_decode u_decode (
    .cfg           (cfg),
    .st            (st),
    .frame_present (frame_present),
    .frame         (frame),
    .plan          (plan_next),
    .st_next       (st_next)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size <= BLOCK_SIZE_RST;
      cfg.sep_time   <= SEP_TIME_RST;
      cfg.max_wait   <= MAX_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE: cfg.block_size <= cfg_data;
        REG_SEP_TIME:   cfg.sep_time   <= cfg_data;
        REG_MAX_WAIT:   cfg.max_wait   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Receive state, advanced per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_take) begin
      st <= st_next;
    end
  end

  // Result list register and emit pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= 4'd0;
    end else if (in_take) begin
      busy <= 1'b1;
      pos  <= 4'd0;
    end else if (out_take) begin
      if (is_last) begin
        busy <= 1'b0;
      end
      pos <= pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      plan <= plan_next;
    end
  end

  // Current result selection
  always_comb begin
    kind           = KIND_END;
    data_byte      = 8'd0;
    fc_status      = FS_CONTINUE;
    fc_block_size  = 8'd0;
    fc_sep_time    = 8'd0;
    message_length = 12'd0;
    end_status     = ES_OK;
    last           = is_last;
    if (pos < {1'b0, plan.n_data}) begin
      kind      = KIND_DATA;
      data_byte = plan.data[pos[2:0]];
    end else if (pos == {1'b0, plan.n_data} && plan.fc_en) begin
      kind          = KIND_FC;
      fc_status     = plan.fc_status;
      fc_block_size = plan.fc_block_size;
      fc_sep_time   = plan.fc_sep_time;
    end else begin
      message_length = plan.end_length;
      end_status     = plan.end_status;
    end
  end

`ifndef SYNTHESIS
  // The emit pointer stays inside the result list
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos < total))
    else $error("emit pointer past end of result list");

  // A reception in progress always owes bytes
  a_rx_owes: assert property (@(posedge clk) disable iff (rst)
    st.receiving |-> (st.bytes_remaining != 12'd0))
    else $error("receiving with nothing owed");

  // An accepted transaction always shows a result next cycle
  a_take_shows: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (out_valid && pos == 4'd0))
    else $error("accepted transaction produced no result");

  // Last result taken with nothing new accepted leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_take && is_last && !in_take) |=> !out_valid)
    else $error("output still valid after last result");
`endif

endmodule
